// ===== rtl/eqvr_pkg.sv =====
package eqvr_pkg;

  // default widths
  localparam int COORD_BITS_DEF = 24;
  localparam int ANGLE_BITS_DEF = 16;

  // configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam logic [1:0] REG_YAW   = 2'd0;
  localparam logic [1:0] REG_PITCH = 2'd1;
  localparam logic [1:0] REG_ROLL  = 2'd2;

  // cordic
  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 33;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

  // fixed-point widths
  localparam int TRIG_W = 18;
  localparam int PAIR_W = 36;
  localparam int TRIP_W = 54;
  localparam int QUAT_W = 18;
  localparam int QPRD_W = 36;
  localparam int MSUM_W = 40;
  localparam int ELEM_W = 29;
  localparam logic signed [ELEM_W-1:0] ELEM_ONE = 29'sd67108864;

  typedef logic signed [ELEM_W-1:0] elem_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic [4:0] idx;
  } cordic_ctl_t;

  // atan(2^-i) as a fraction of a turn, 2^32 per turn
  function automatic logic signed [CW-1:0] atan_step(input logic [4:0] i);
    logic signed [CW-1:0] r;
    begin
      case (i)
        5'd0:  r = 33'sh020000000;
        5'd1:  r = 33'sh012E4051E;
        5'd2:  r = 33'sh009FB385B;
        5'd3:  r = 33'sh0051111D4;
        5'd4:  r = 33'sh0028B0D43;
        5'd5:  r = 33'sh00145D7E1;
        5'd6:  r = 33'sh000A2F61E;
        5'd7:  r = 33'sh000517C55;
        5'd8:  r = 33'sh00028BE53;
        5'd9:  r = 33'sh000145F2F;
        5'd10: r = 33'sh0000A2F98;
        5'd11: r = 33'sh0000517CC;
        5'd12: r = 33'sh000028BE6;
        5'd13: r = 33'sh0000145F3;
        5'd14: r = 33'sh00000A2FA;
        5'd15: r = 33'sh00000517D;
        5'd16: r = 33'sh0000028BE;
        5'd17: r = 33'sh00000145F;
        5'd18: r = 33'sh000000A30;
        5'd19: r = 33'sh000000518;
        5'd20: r = 33'sh00000028C;
        5'd21: r = 33'sh000000146;
        5'd22: r = 33'sh0000000A3;
        5'd23: r = 33'sh000000051;
        5'd24: r = 33'sh000000029;
        5'd25: r = 33'sh000000014;
        5'd26: r = 33'sh00000000A;
        5'd27: r = 33'sh000000005;
        5'd28: r = 33'sh000000003;
        5'd29: r = 33'sh000000001;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // Q48 sum to Q16, round then clamp to 18 bits signed
  function automatic logic signed [QUAT_W-1:0] quat_round(input logic signed [TRIP_W-1:0] v);
    logic signed [TRIP_W-1:0] t;
    logic signed [TRIP_W-1:0] s;
    logic signed [QUAT_W-1:0] r;
    begin
      t = v + (TRIP_W'(1) <<< 31);
      s = t >>> 32;
      if (s > TRIP_W'(131071))        r = 18'sd131071;
      else if (s < -TRIP_W'(131072))  r = -18'sd131072;
      else                            r = s[QUAT_W-1:0];
      return r;
    end
  endfunction

  // Q32 matrix element to Q26, round then clamp to +-2^27
  function automatic elem_t elem_round(input logic signed [MSUM_W-1:0] v);
    logic signed [MSUM_W-1:0] t;
    logic signed [MSUM_W-1:0] s;
    elem_t r;
    begin
      t = v + MSUM_W'(32);
      s = t >>> 6;
      if (s > (MSUM_W'(1) <<< 27))        r = 29'sd134217728;
      else if (s < -(MSUM_W'(1) <<< 27))  r = -29'sd134217728;
      else                                r = s[ELEM_W-1:0];
      return r;
    end
  endfunction

endpackage

// ===== rtl/eqvr_if.sv =====
interface eqvr_vec_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vec_x;
  logic signed [COORD_BITS-1:0] vec_y;
  logic signed [COORD_BITS-1:0] vec_z;
  modport source (output valid, vec_x, vec_y, vec_z, input ready);
  modport sink   (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface eqvr_rot_if #(parameter int COORD_BITS = 24);
  logic                       valid;
  logic                       ready;
  logic signed [COORD_BITS:0] rot_x;
  logic signed [COORD_BITS:0] rot_y;
  logic signed [COORD_BITS:0] rot_z;
  logic                       saturated;
  modport source (output valid, rot_x, rot_y, rot_z, saturated, input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, saturated, output ready);
endinterface

// ===== rtl/eqvr_cordic.sv =====
module eqvr_cordic #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                                 clk,
  input  eqvr_pkg::cordic_ctl_t                ctl,
  input  logic signed [ANGLE_BITS-1:0]         angle,
  output logic signed [eqvr_pkg::TRIG_W-1:0]   cos_q16,
  output logic signed [eqvr_pkg::TRIG_W-1:0]   sin_q16
);
  import eqvr_pkg::*;

  logic signed [CW-1:0] x_r, y_r, z_r;
  logic signed [CW-1:0] x_nxt, y_nxt, z_nxt;
  logic signed [CW-1:0] z0, dx, dy, at, xr, yr;

  // half angle phase, 2^32 per turn
  assign z0 = $signed({{(CW-ANGLE_BITS){angle[ANGLE_BITS-1]}}, angle}) <<< (31 - ANGLE_BITS);

  // one rotation step per cycle while ctl.step is set
  always_comb begin
    dx = y_r >>> ctl.idx;
    dy = x_r >>> ctl.idx;
    at = atan_step(ctl.idx);
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (ctl.load) begin
      x_nxt = CORDIC_GAIN;
      y_nxt = '0;
      z_nxt = z0;
    end else if (ctl.step) begin
      if (!z_r[CW-1]) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  // q30 to q16 with rounding
  assign xr = x_r + CW'(8192);
  assign yr = y_r + CW'(8192);
  assign cos_q16 = xr[TRIG_W+13:14];
  assign sin_q16 = yr[TRIG_W+13:14];

endmodule

// ===== rtl/eqvr_coef.sv =====
module eqvr_coef #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [1:0]                    wr_idx,
  input  logic [eqvr_pkg::CFG_DW-1:0]   wr_data,
  output logic signed [ANGLE_BITS-1:0]  yaw,
  output logic signed [ANGLE_BITS-1:0]  pitch,
  output logic signed [ANGLE_BITS-1:0]  roll,
  output logic                          busy,
  output eqvr_pkg::elem_t               mat [9]
);
  import eqvr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROT  = 3'd1;
  localparam logic [2:0] S_PAIR = 3'd2;
  localparam logic [2:0] S_QUAT = 3'd3;
  localparam logic [2:0] S_PROD = 3'd4;
  localparam logic [2:0] S_ELEM = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic signed [ANGLE_BITS-1:0] yaw_r, pitch_r, roll_r;
  logic signed [ANGLE_BITS-1:0] yaw_nxt, pitch_nxt, roll_nxt;
  logic        hit;
  cordic_ctl_t ctl;

  logic signed [TRIG_W-1:0] cy, sy, cp, sp, cr, sr;
  logic signed [PAIR_W-1:0] cc_r, ss_r, sc_r, cs_r;
  logic signed [TRIG_W-1:0] cr_r, sr_r;
  logic signed [QUAT_W-1:0] qw_r, qx_r, qy_r, qz_r;
  logic signed [QPRD_W-1:0] ww_r, xx_r, yy_r, zz_r, xy_r, wz_r, wy_r, xz_r, yz_r, wx_r;
  elem_t mat_r [9];

  // angle registers, low bits of the write data kept
  always_comb begin
    yaw_nxt   = yaw_r;
    pitch_nxt = pitch_r;
    roll_nxt  = roll_r;
    hit       = 1'b0;
    if (wr_en) begin
      unique case (wr_idx)
        REG_YAW:   begin yaw_nxt   = wr_data[ANGLE_BITS-1:0]; hit = 1'b1; end
        REG_PITCH: begin pitch_nxt = wr_data[ANGLE_BITS-1:0]; hit = 1'b1; end
        REG_ROLL:  begin roll_nxt  = wr_data[ANGLE_BITS-1:0]; hit = 1'b1; end
        default:   hit = 1'b0;
      endcase
    end
  end

  // recompute sequencer, a write to an angle register restarts it
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: state_nxt = S_IDLE;
      S_ROT: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(CORDIC_STEPS - 1)) state_nxt = S_PAIR;
      end
      S_PAIR: state_nxt = S_QUAT;
      S_QUAT: state_nxt = S_PROD;
      S_PROD: state_nxt = S_ELEM;
      S_ELEM: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (hit) begin
      state_nxt = S_ROT;
      cnt_nxt   = '0;
    end
  end

  assign ctl.load = hit;
  assign ctl.step = (state_r == S_ROT);
  assign ctl.idx  = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      yaw_r   <= '0;
      pitch_r <= '0;
      roll_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      yaw_r   <= yaw_nxt;
      pitch_r <= pitch_nxt;
      roll_r  <= roll_nxt;
    end
  end

  // three angle lanes side by side
  eqvr_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cyaw (
    .clk(clk), .ctl(ctl), .angle(yaw_nxt), .cos_q16(cy), .sin_q16(sy));
  eqvr_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cpitch (
    .clk(clk), .ctl(ctl), .angle(pitch_nxt), .cos_q16(cp), .sin_q16(sp));
  eqvr_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_croll (
    .clk(clk), .ctl(ctl), .angle(roll_nxt), .cos_q16(cr), .sin_q16(sr));

  // yaw-pitch pair products
  always_ff @(posedge clk) begin
    if (state_r == S_PAIR) begin
      cc_r <= PAIR_W'(cy) * PAIR_W'(cp);
      ss_r <= PAIR_W'(sy) * PAIR_W'(sp);
      sc_r <= PAIR_W'(sy) * PAIR_W'(cp);
      cs_r <= PAIR_W'(cy) * PAIR_W'(sp);
      cr_r <= cr;
      sr_r <= sr;
    end
  end

  // quaternion
  always_ff @(posedge clk) begin
    if (state_r == S_QUAT) begin
      qw_r <= quat_round(TRIP_W'(cc_r) * TRIP_W'(cr_r) + TRIP_W'(ss_r) * TRIP_W'(sr_r));
      qx_r <= quat_round(TRIP_W'(cc_r) * TRIP_W'(sr_r) - TRIP_W'(ss_r) * TRIP_W'(cr_r));
      qy_r <= quat_round(TRIP_W'(sc_r) * TRIP_W'(sr_r) + TRIP_W'(cs_r) * TRIP_W'(cr_r));
      qz_r <= quat_round(TRIP_W'(sc_r) * TRIP_W'(cr_r) - TRIP_W'(cs_r) * TRIP_W'(sr_r));
    end
  end

  // quaternion pair products
  always_ff @(posedge clk) begin
    if (state_r == S_PROD) begin
      ww_r <= QPRD_W'(qw_r) * QPRD_W'(qw_r);
      xx_r <= QPRD_W'(qx_r) * QPRD_W'(qx_r);
      yy_r <= QPRD_W'(qy_r) * QPRD_W'(qy_r);
      zz_r <= QPRD_W'(qz_r) * QPRD_W'(qz_r);
      xy_r <= QPRD_W'(qx_r) * QPRD_W'(qy_r);
      wz_r <= QPRD_W'(qw_r) * QPRD_W'(qz_r);
      wy_r <= QPRD_W'(qw_r) * QPRD_W'(qy_r);
      xz_r <= QPRD_W'(qx_r) * QPRD_W'(qz_r);
      yz_r <= QPRD_W'(qy_r) * QPRD_W'(qz_r);
      wx_r <= QPRD_W'(qw_r) * QPRD_W'(qx_r);
    end
  end

  // rotation matrix, identity after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 9; k++) mat_r[k] <= '0;
      mat_r[0] <= ELEM_ONE;
      mat_r[4] <= ELEM_ONE;
      mat_r[8] <= ELEM_ONE;
    end else if (state_r == S_ELEM) begin
      mat_r[0] <= elem_round(MSUM_W'(ww_r) + MSUM_W'(xx_r) - MSUM_W'(yy_r) - MSUM_W'(zz_r));
      mat_r[1] <= elem_round((MSUM_W'(xy_r) - MSUM_W'(wz_r)) <<< 1);
      mat_r[2] <= elem_round((MSUM_W'(wy_r) + MSUM_W'(xz_r)) <<< 1);
      mat_r[3] <= elem_round((MSUM_W'(wz_r) + MSUM_W'(xy_r)) <<< 1);
      mat_r[4] <= elem_round(MSUM_W'(ww_r) - MSUM_W'(xx_r) + MSUM_W'(yy_r) - MSUM_W'(zz_r));
      mat_r[5] <= elem_round((MSUM_W'(yz_r) - MSUM_W'(wx_r)) <<< 1);
      mat_r[6] <= elem_round((MSUM_W'(xz_r) - MSUM_W'(wy_r)) <<< 1);
      mat_r[7] <= elem_round((MSUM_W'(wx_r) + MSUM_W'(yz_r)) <<< 1);
      mat_r[8] <= elem_round(MSUM_W'(ww_r) - MSUM_W'(xx_r) - MSUM_W'(yy_r) + MSUM_W'(zz_r));
    end
  end

  assign yaw   = yaw_r;
  assign pitch = pitch_r;
  assign roll  = roll_r;
  assign busy  = (state_r != S_IDLE);
  assign mat   = mat_r;

endmodule

// ===== rtl/eqvr_lane.sv =====
module eqvr_lane #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         en1,
  input  logic                         en2,
  input  logic signed [COORD_BITS-1:0] vec [3],
  input  eqvr_pkg::elem_t              row [3],
  output logic signed [COORD_BITS:0]   comp,
  output logic                         sat
);
  import eqvr_pkg::*;

  localparam int PW = COORD_BITS + ELEM_W;
  localparam int AW = PW + 2;

  logic signed [PW-1:0]     p_r [3];
  logic signed [AW-1:0]     acc, rnd, sh, hi, lo;
  logic signed [COORD_BITS:0] comp_r, comp_nxt;
  logic                       sat_r, sat_nxt;

  // products of one matrix row
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int k = 0; k < 3; k++) p_r[k] <= PW'(vec[k]) * PW'(row[k]);
    end
  end

  // sum, round and clamp
  always_comb begin
    acc = AW'(p_r[0]) + AW'(p_r[1]) + AW'(p_r[2]);
    rnd = acc + (AW'(1) <<< 25);
    sh  = rnd >>> 26;
    hi  = (AW'(1) <<< COORD_BITS) - AW'(1);
    lo  = -(AW'(1) <<< COORD_BITS);
    sat_nxt  = 1'b0;
    comp_nxt = sh[COORD_BITS:0];
    if (sh > hi) begin
      comp_nxt = hi[COORD_BITS:0];
      sat_nxt  = 1'b1;
    end else if (sh < lo) begin
      comp_nxt = lo[COORD_BITS:0];
      sat_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      comp_r <= comp_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign comp = comp_r;
  assign sat  = sat_r;

endmodule

// ===== rtl/euler_quaternion_vector_rotate_unit.sv =====
// channel   dir  handshake      word
// in_ch     in   valid/ready    vec_x, vec_y, vec_z (signed COORD_BITS)
// out_ch    out  valid/ready    rot_x, rot_y, rot_z (signed COORD_BITS+1), saturated
// apb       in   psel/penable   yaw, pitch, roll angle at 0x0, 0x4, 0x8
//
// one word per cycle when not stalled, through product, sum and output registers
// an angle write holds in_ch.ready low while the matrix is rebuilt
// (30 cordic steps, then pair, quaternion, product and element stages)
// synchronous active-low reset gives the identity rotation and zero angles
// each stage moves when the one after it is empty or moving, so stalls back up
// only as far as needed
module euler_quaternion_vector_rotate_unit #(
  parameter int COORD_BITS = eqvr_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = eqvr_pkg::ANGLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  eqvr_vec_if.sink                    in_ch,
  eqvr_rot_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [eqvr_pkg::CFG_AW-1:0] paddr,
  input  logic [eqvr_pkg::CFG_DW-1:0] pwdata,
  output logic [eqvr_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import eqvr_pkg::*;

  logic                         wr_en, busy;
  logic [1:0]                   reg_idx;
  logic signed [ANGLE_BITS-1:0] yaw, pitch, roll;
  elem_t                        mat [9];
  logic signed [COORD_BITS-1:0] vec [3];
  logic signed [COORD_BITS:0]   comp [3];
  logic [2:0]                   sat;
  logic v1_r, v2_r, vo_r;
  logic adv1, adv2, advo;
  logic signed [COORD_BITS:0] rx_r, ry_r, rz_r;
  logic                       sat_r;

  // configuration port
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    unique case (reg_idx)
      REG_YAW:   prdata = CFG_DW'(yaw);
      REG_PITCH: prdata = CFG_DW'(pitch);
      REG_ROLL:  prdata = CFG_DW'(roll);
      default:   prdata = '0;
    endcase
  end

  eqvr_coef #(.ANGLE_BITS(ANGLE_BITS)) u_coef (
    .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_idx(reg_idx), .wr_data(pwdata),
    .yaw(yaw), .pitch(pitch), .roll(roll), .busy(busy), .mat(mat));

  // pipeline flow
  assign advo = !vo_r | out_ch.ready;
  assign adv2 = !v2_r | advo;
  assign adv1 = !v1_r | adv2;
  assign in_ch.ready = adv1 & !busy;

  assign vec[0] = in_ch.vec_x;
  assign vec[1] = in_ch.vec_y;
  assign vec[2] = in_ch.vec_z;

  // one lane per matrix row
  for (genvar r = 0; r < 3; r++) begin : g_lane
    elem_t row [3];
    assign row[0] = mat[3*r];
    assign row[1] = mat[3*r+1];
    assign row[2] = mat[3*r+2];
    eqvr_lane #(.COORD_BITS(COORD_BITS)) u_lane (
      .clk(clk), .en1(adv1), .en2(adv2), .vec(vec), .row(row),
      .comp(comp[r]), .sat(sat[r]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_ch.valid & in_ch.ready;
      if (adv2) v2_r <= v1_r;
      if (advo) vo_r <= v2_r;
    end
  end

  // merge lanes into the output word
  always_ff @(posedge clk) begin
    if (advo) begin
      rx_r  <= comp[0];
      ry_r  <= comp[1];
      rz_r  <= comp[2];
      sat_r <= |sat;
    end
  end

  assign out_ch.valid     = vo_r;
  assign out_ch.rot_x     = rx_r;
  assign out_ch.rot_y     = ry_r;
  assign out_ch.rot_z     = rz_r;
  assign out_ch.saturated = sat_r;

`ifndef SYNTHESIS
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready) else $error("word taken during matrix rebuild");
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v1_r) else $error("accepted word lost");
  a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.saturated) |->
      (rx_r == (COORD_BITS+1)'((1 <<< COORD_BITS) - 1) || rx_r == -(1 <<< COORD_BITS) ||
       ry_r == (COORD_BITS+1)'((1 <<< COORD_BITS) - 1) || ry_r == -(1 <<< COORD_BITS) ||
       rz_r == (COORD_BITS+1)'((1 <<< COORD_BITS) - 1) || rz_r == -(1 <<< COORD_BITS)))
    else $error("saturated flag without clamped component");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid) else $error("output valid after reset");
`endif

endmodule

// ===== bench/tb_euler_quaternion_vector_rotate_unit.sv =====
`timescale 1ns / 100ps

module tb_euler_quaternion_vector_rotate_unit;
  import eqvr_pkg::*;

  localparam int CB = 24;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  eqvr_vec_if #(.COORD_BITS(CB)) vec_ch ();
  eqvr_rot_if #(.COORD_BITS(CB)) rot_ch ();

  euler_quaternion_vector_rotate_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(vec_ch.sink), .out_ch(rot_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  typedef struct {
    logic signed [CB:0] x, y, z;
    logic               sat;
  } rot_word_t;

  typedef struct {
    logic signed [CB-1:0] x, y, z;
    logic                 known;
    rot_word_t            res;
  } vec_row_t;

  // predictor state
  longint angle_q[3];
  longint qw, qx, qy, qz;
  longint atan_tbl[30] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};

  rot_word_t rotated_q[$];
  int errors = 0;
  bit long_hold = 0;
  bit rand_on = 0;
  bit src_done = 0;

  function automatic longint clip(longint v, longint lo, longint hi, ref bit f);
    if (v > hi) begin f = 1; return hi; end
    if (v < lo) begin f = 1; return lo; end
    return v;
  endfunction

  // half-angle cordic, q30 result rounded to q16
  task automatic half_trig(input longint ang, output longint c, output longint s);
    longint z, x, y, dx, dy;
    z = ang * (longint'(1) << 15);
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tbl[i];
      end else begin
        x += dx; y -= dy; z += atan_tbl[i];
      end
    end
    c = (x + 8192) >>> 14;
    s = (y + 8192) >>> 14;
  endtask

  function automatic longint to_q16(longint v);
    bit f;
    return clip((v + (longint'(1) << 31)) >>> 32, -131072, 131071, f);
  endfunction

  task automatic rebuild_quat();
    longint cy, sy, cp, sp, cr, sr;
    half_trig(angle_q[0], cy, sy);
    half_trig(angle_q[1], cp, sp);
    half_trig(angle_q[2], cr, sr);
    qw = to_q16(cy * cp * cr + sy * sp * sr);
    qx = to_q16(cy * cp * sr - sy * sp * cr);
    qy = to_q16(sy * cp * sr + cy * sp * cr);
    qz = to_q16(sy * cp * cr - cy * sp * sr);
  endtask

  function automatic longint to_elem(longint v);
    bit f;
    return clip((v + 32) >>> 6, -(longint'(1) << 27), longint'(1) << 27, f);
  endfunction

  function automatic rot_word_t rotate_vec(logic signed [CB-1:0] vx,
                                           logic signed [CB-1:0] vy,
                                           logic signed [CB-1:0] vz);
    longint m[9];
    longint v[3];
    longint acc;
    bit f;
    rot_word_t r;
    f = 0;
    m[0] = to_elem(qw*qw + qx*qx - qy*qy - qz*qz);
    m[1] = to_elem(2 * (qx*qy - qw*qz));
    m[2] = to_elem(2 * (qw*qy + qx*qz));
    m[3] = to_elem(2 * (qw*qz + qx*qy));
    m[4] = to_elem(qw*qw - qx*qx + qy*qy - qz*qz);
    m[5] = to_elem(2 * (qy*qz - qw*qx));
    m[6] = to_elem(2 * (qx*qz - qw*qy));
    m[7] = to_elem(2 * (qw*qx + qy*qz));
    m[8] = to_elem(qw*qw - qx*qx - qy*qy + qz*qz);
    v[0] = vx; v[1] = vy; v[2] = vz;
    for (int r_i = 0; r_i < 3; r_i++) begin
      acc = v[0]*m[3*r_i] + v[1]*m[3*r_i+1] + v[2]*m[3*r_i+2];
      acc = clip((acc + (longint'(1) << 25)) >>> 26, -(longint'(1) << CB),
                 (longint'(1) << CB) - 1, f);
      if (r_i == 0) r.x = acc[CB:0];
      else if (r_i == 1) r.y = acc[CB:0];
      else r.z = acc[CB:0];
    end
    r.sat = f;
    return r;
  endfunction

  // apb write, then read back
  task automatic write_angle(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= CFG_AW'({idx, 2'b00}); pwdata <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx <= REG_ROLL) begin
      angle_q[idx] = longint'($signed(val[15:0]));
      rebuild_quat();
    end
    @(posedge clk);
    psel <= 1; paddr <= CFG_AW'({idx, 2'b00});
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    if (idx <= REG_ROLL && prdata[15:0] !== val[15:0]) begin
      $error("angle readback: expected %h actual %h", val[15:0], prdata[15:0]);
      errors++;
    end
    psel <= 0; penable <= 0;
  endtask

  task automatic drain();
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_word(input vec_row_t row);
    vec_ch.valid <= 1;
    vec_ch.vec_x <= row.x; vec_ch.vec_y <= row.y; vec_ch.vec_z <= row.z;
    do @(posedge clk); while (!vec_ch.ready);
    rotated_q.push_back(row.known ? row.res : rotate_vec(row.x, row.y, row.z));
  endtask

  function automatic vec_row_t rand_row();
    vec_row_t r;
    int sel;
    sel = $urandom_range(0, 9);
    r.x = CB'($urandom); r.y = CB'($urandom); r.z = CB'($urandom);
    if (sel < 3) begin
      r.x = CB'(int'($urandom_range(0, 2000)) - 1000);
      r.y = CB'(int'($urandom_range(0, 2000)) - 1000);
    end
    r.known = 0;
    return r;
  endfunction

  // receiver stall pattern with one long hold
  always @(posedge clk) begin
    if (!rst_n) rot_ch.ready <= 0;
    else if (long_hold) rot_ch.ready <= 0;
    else rot_ch.ready <= ($urandom_range(0, 7) != 0) || ($urandom_range(0, 3) == 0);
  end

  // result checker
  always @(posedge clk) begin
    rot_word_t e;
    if (rst_n && rot_ch.valid && rot_ch.ready) begin
      if (rotated_q.size() == 0) begin
        $error("unexpected rotated word");
        errors++;
      end else begin
        e = rotated_q.pop_front();
        if (rot_ch.rot_x !== e.x) begin
          $error("rot_x expected %0d actual %0d", e.x, rot_ch.rot_x); errors++;
        end
        if (rot_ch.rot_y !== e.y) begin
          $error("rot_y expected %0d actual %0d", e.y, rot_ch.rot_y); errors++;
        end
        if (rot_ch.rot_z !== e.z) begin
          $error("rot_z expected %0d actual %0d", e.z, rot_ch.rot_z); errors++;
        end
        if (rot_ch.saturated !== e.sat) begin
          $error("saturated expected %0d actual %0d", e.sat, rot_ch.saturated); errors++;
        end
      end
    end
  end

  // long receiver hold while the random stream runs, counted in cycles
  initial begin
    wait (rand_on && !src_done);
    repeat (40) @(posedge clk);
    long_hold = 1;
    repeat (200) @(posedge clk);
    long_hold = 0;
  end

  // run limit
  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  localparam logic signed [CB-1:0] VMAX = 24'sh7FFFFF;
  localparam logic signed [CB-1:0] VMIN = -24'sh800000;

  vec_row_t dir_tbl[] = '{
    '{24'sd1, 24'sd2, 24'sd3, 1'b1, '{25'sd1, 25'sd2, 25'sd3, 1'b0}},
    '{VMAX, VMAX, VMAX, 1'b1, '{25'sd8388607, 25'sd8388607, 25'sd8388607, 1'b0}},
    '{VMIN, VMIN, VMIN, 1'b1, '{-25'sd8388608, -25'sd8388608, -25'sd8388608, 1'b0}},
    '{24'sd0, 24'sd0, 24'sd0, 1'b1, '{25'sd0, 25'sd0, 25'sd0, 1'b0}},
    '{24'sh555555, -24'sh2AAAAB, 24'sd0, 1'b0, '{0, 0, 0, 1'b0}},
    '{VMAX, VMIN, VMAX, 1'b0, '{0, 0, 0, 1'b0}},
    '{VMIN, VMAX, VMIN, 1'b0, '{0, 0, 0, 1'b0}},
    '{-24'sd1, 24'sd1, -24'sd1, 1'b0, '{0, 0, 0, 1'b0}}
  };

  logic [31:0] angle_sets[6][3] = '{
    '{32'h0000_4000, 32'h0000_0000, 32'h0000_0000},
    '{32'h0000_8000, 32'h0000_7FFF, 32'h0001_8000},
    '{32'h0000_2000, 32'h0000_2000, 32'h0000_2000},
    '{32'hFFFF_C000, 32'h0000_1234, 32'hABCD_0001},
    '{32'h0000_7FFF, 32'h0000_8000, 32'h0000_FFFF},
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000}
  };

  initial begin
    int sent;
    int burst;
    angle_q = '{0, 0, 0};
    qw = 65536; qx = 0; qy = 0; qz = 0;
    vec_ch.valid = 0; vec_ch.vec_x = 0; vec_ch.vec_y = 0; vec_ch.vec_z = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed rows at identity, then under several angle settings
    foreach (dir_tbl[i]) send_word(dir_tbl[i]);
    vec_ch.valid <= 0;
    drain();
    foreach (angle_sets[s]) begin
      for (int r = 0; r < 3; r++) write_angle(r[1:0], angle_sets[s][r]);
      write_angle(2'd3, 32'hFFFF);
      foreach (dir_tbl[i]) begin
        vec_row_t row;
        row = dir_tbl[i];
        row.known = 0;
        send_word(row);
      end
      vec_ch.valid <= 0;
      drain();
    end

    // random phases, bursts with gaps
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      for (int r = 0; r < 3; r++) write_angle(r[1:0], $urandom);
      rand_on = 1;
      while (sent < (ph + 1) * 160) begin
        burst = $urandom_range(1, 30);
        repeat (burst) begin
          send_word(rand_row());
          sent++;
        end
        if ($urandom_range(0, 2) != 0) begin
          vec_ch.valid <= 0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
      vec_ch.valid <= 0;
      drain();
    end
    src_done = 1;

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
